FILE: sv/dual_feedback_bus_scanner_top_macros.svh
// assertion macros for the dual feedback bus scanner
`ifndef DUAL_FEEDBACK_BUS_SCANNER_TOP_MACROS_SVH
`define DUAL_FEEDBACK_BUS_SCANNER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DFBS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dfbs assertion failed");
`define DFBS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dfbs forbidden condition seen");
`else
`define DFBS_ASSERT(label, clk, rst_n, prop)
`define DFBS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/dfbs_pkg.sv
// shared types and constants of the dual feedback bus scanner
package dfbs_pkg;

	localparam int MAX_MODULES = 64;
	localparam int MODULE_BITS = 8;
	localparam int MB_LOG      = $clog2(MODULE_BITS);
	localparam int MC_W        = 7;
	localparam int ID_W        = 10;
	localparam int ADDR_W      = 3;

	localparam logic REG_MODULE_COUNT = 1'b0;

	typedef struct packed {
		logic left;
		logic right;
	} pair_t;

	typedef struct packed {
		logic  shift;
		pair_t bits;
	} chain_ctl_t;

	typedef struct packed {
		logic            en;
		logic [MC_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic            frame_done;
		logic            right_state;
		logic [ID_W-1:0] right_sensor_id;
		logic            right_report;
		logic            left_state;
		logic [ID_W-1:0] left_sensor_id;
		logic            left_report;
		logic            clock_pulse;
		logic            reset_level;
		logic            load_level;
	} res_t;

endpackage

FILE: sv/dual_feedback_bus_scanner_top.sv
// Dual feedback bus scanner: each input transaction is one bus tick and yields exactly one
// result transaction, held in the output register or its skid. One tick is taken every
// cycle while the skid is empty; the rate is set by the combinational compare against the
// head cell of the history chain, which shifts once per read tick. The previous frame's
// bits live in a chain of MAX_MODULES/2*8 cells (256 by default), each holding one
// left/right bit pair; the fresh sample enters at the cell given by the frame length and
// reaches the head exactly one frame later. A two-deep output stage (register plus skid)
// keeps s_tready high while only one result waits. No clearing pass: after reset or a
// module_count write the first frame reports every bit, so untouched cells are never used.
`include "dual_feedback_bus_scanner_top_macros.svh"

module dual_feedback_bus_scanner_top #(
	parameter int MAX_MODULES = dfbs_pkg::MAX_MODULES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // data_left, data_right, zero fill
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// load_level, reset_level, clock_pulse, left_report, left_sensor_id, left_state,
	// right_report, right_sensor_id, right_state, zero fill
	output logic [31:0]                   m_tdata,
	output logic                          m_tlast,  // frame_done
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dfbs_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int HIST_DEPTH = MAX_MODULES / 2 * dfbs_pkg::MODULE_BITS;
	localparam int POS_W      = $clog2(HIST_DEPTH);

	dfbs_pkg::cfg_wr_t             cfg;
	dfbs_pkg::chain_ctl_t          chain_ctl;
	dfbs_pkg::res_t                res;
	dfbs_pkg::pair_t               cell_bits [HIST_DEPTH];
	logic [POS_W-1:0]              tail;
	logic [dfbs_pkg::MC_W-1:0]     module_count;
	logic                          acc;
	logic                          take;

	dfbs_pkg::res_t                out_q;
	dfbs_pkg::res_t                skid_q;
	logic                          out_valid_q;
	logic                          skid_valid_q;

	assign pready    = 1'b1;
	assign cfg.en    = psel && penable && pwrite && pready &&
		(paddr[2] == dfbs_pkg::REG_MODULE_COUNT);
	assign cfg.value = pwdata[dfbs_pkg::MC_W-1:0];
	assign prdata    = (paddr[2] == dfbs_pkg::REG_MODULE_COUNT) ?
		{{(32 - dfbs_pkg::MC_W){1'b0}}, module_count} : '0;

	assign s_tready = !skid_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign take     = out_valid_q && m_tready;

	dfbs_seq #(
		.MAX_MODULES(MAX_MODULES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.acc          (acc),
		.data_left    (s_tdata[0]),
		.data_right   (s_tdata[1]),
		.old_bits     (cell_bits[0]),
		.tail         (tail),
		.chain_ctl    (chain_ctl),
		.res          (res),
		.module_count (module_count)
	);

	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
		dfbs_pkg::pair_t nbr;
		if (k == HIST_DEPTH - 1) begin : g_end
			assign nbr = chain_ctl.bits;
		end else begin : g_mid
			assign nbr = cell_bits[k + 1];
		end
		dfbs_cell u_cell (
			.clk     (clk),
			.ctl     (chain_ctl),
			.is_tail (tail == POS_W'(k)),
			.nbr     (nbr),
			.held    (cell_bits[k])
		);
	end

	// result register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!acc) begin
				out_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res;
			end
		end else if (acc) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.frame_done;
	assign m_tdata  = {5'b0, out_q.right_state, out_q.right_sensor_id, out_q.right_report,
		out_q.left_state, out_q.left_sensor_id, out_q.left_report, out_q.clock_pulse,
		out_q.reset_level, out_q.load_level};

	`DFBS_ASSERT(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`DFBS_ASSERT(a_load_no_report, clk, arst_n, (out_valid_q && out_q.load_level) |-> (!out_q.left_report && !out_q.right_report && !out_q.frame_done))
	`DFBS_ASSERT(a_done_has_clock, clk, arst_n, (out_valid_q && out_q.frame_done) |-> out_q.clock_pulse)
	`DFBS_ASSERT_NEVER(a_shift_on_load, clk, arst_n, chain_ctl.shift && res.load_level)

endmodule

FILE: sv/dfbs_cell.sv
// one history cell: holds the previous frame's bit pair for one position
module dfbs_cell (
	input  logic                  clk,
	input  dfbs_pkg::chain_ctl_t  ctl,
	input  logic                  is_tail,
	input  dfbs_pkg::pair_t       nbr,
	output dfbs_pkg::pair_t       held
);

	dfbs_pkg::pair_t held_q;

	// tail cell takes the fresh sample, the others take their neighbour
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			held_q <= is_tail ? ctl.bits : nbr;
		end
	end

	assign held = held_q;

endmodule

FILE: sv/dfbs_seq.sv
// frame sequencer: config register, scan phase, bit position and report forming
`include "dual_feedback_bus_scanner_top_macros.svh"

module dfbs_seq #(
	parameter int MAX_MODULES = dfbs_pkg::MAX_MODULES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfbs_pkg::cfg_wr_t             cfg,
	input  logic                          acc,
	input  logic                          data_left,
	input  logic                          data_right,
	input  dfbs_pkg::pair_t               old_bits,
	output logic [$clog2(MAX_MODULES / 2 * dfbs_pkg::MODULE_BITS)-1:0] tail,
	output dfbs_pkg::chain_ctl_t          chain_ctl,
	output dfbs_pkg::res_t                res,
	output logic [dfbs_pkg::MC_W-1:0]     module_count
);

	localparam int HIST_DEPTH = MAX_MODULES / 2 * dfbs_pkg::MODULE_BITS;
	localparam int POS_W      = $clog2(HIST_DEPTH);
	localparam int ID_W       = dfbs_pkg::ID_W;

	typedef enum logic {
		PH_LOAD,
		PH_READ
	} phase_t;

	phase_t                      phase_q;
	logic [POS_W-1:0]            pos_q;
	logic                        primed_q;
	logic [dfbs_pkg::MC_W-1:0]   mc_q;

	logic            cfg_ok;
	logic            running;
	logic            last_pos;
	logic [ID_W-1:0] half;
	logic [ID_W-1:0] half_m1;
	logic [ID_W-1:0] pos_ext;

	assign cfg_ok   = cfg.en && !cfg.value[0] &&
		(cfg.value <= dfbs_pkg::MC_W'(MAX_MODULES));
	assign running  = (mc_q != '0);
	assign half     = ID_W'(mc_q >> 1) << dfbs_pkg::MB_LOG;
	assign half_m1  = half - ID_W'(1);
	assign tail     = half_m1[POS_W-1:0];
	assign last_pos = (pos_q == tail);
	assign pos_ext  = ID_W'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q     <= dfbs_pkg::MC_W'(64);
			phase_q  <= PH_LOAD;
			pos_q    <= '0;
			primed_q <= 1'b0;
		end else if (cfg_ok) begin
			mc_q     <= cfg.value;
			phase_q  <= PH_LOAD;
			pos_q    <= '0;
			primed_q <= 1'b0;
		end else if (acc && running) begin
			unique case (phase_q)
				PH_LOAD: begin
					phase_q <= PH_READ;
					pos_q   <= '0;
				end
				PH_READ: begin
					if (last_pos) begin
						phase_q  <= PH_LOAD;
						pos_q    <= '0;
						primed_q <= 1'b1;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				default: phase_q <= PH_LOAD;
			endcase
		end
	end

	assign chain_ctl.shift      = acc && running && (phase_q == PH_READ) && !cfg_ok;
	assign chain_ctl.bits.left  = data_left;
	assign chain_ctl.bits.right = data_right;

	always_comb begin
		res = '0;
		if (running) begin
			if (phase_q == PH_LOAD) begin
				res.load_level  = 1'b1;
				res.reset_level = 1'b1;
				res.clock_pulse = 1'b1;
			end else begin
				res.clock_pulse = 1'b1;
				res.frame_done  = last_pos;
				if (!primed_q || (old_bits.left != data_left)) begin
					res.left_report    = 1'b1;
					res.left_sensor_id = pos_ext + ID_W'(1);
					res.left_state     = data_left;
				end
				if (!primed_q || (old_bits.right != data_right)) begin
					res.right_report    = 1'b1;
					res.right_sensor_id = half + pos_ext + ID_W'(1);
					res.right_state     = data_right;
				end
			end
		end
	end

	assign module_count = mc_q;

	`DFBS_ASSERT(a_pos_in_frame, clk, arst_n, running |-> (pos_q <= tail))
	`DFBS_ASSERT(a_count_even, clk, arst_n, 1'b1 |-> (mc_q[0] == 1'b0))
	`DFBS_ASSERT(a_frame_wrap, clk, arst_n, (chain_ctl.shift && last_pos) |=> ((phase_q == PH_LOAD) && (pos_q == '0) && primed_q))
	`DFBS_ASSERT(a_load_to_read, clk, arst_n, (acc && running && (phase_q == PH_LOAD) && !cfg_ok) |=> (phase_q == PH_READ))

endmodule

FILE: tb/sv/dual_feedback_bus_scanner_top_tb.sv
// self-checking testbench for the dual feedback bus scanner top level
module dual_feedback_bus_scanner_top_tb;

	localparam int HIST_DEPTH  = dfbs_pkg::MAX_MODULES / 2 * dfbs_pkg::MODULE_BITS;
	localparam int REG_SPARE   = 1;
	localparam int HOLD_CYCLES = 48;
	localparam int QUIET_LIMIT = 2000;

	typedef enum logic {PHASE_LOAD, PHASE_READ} scan_phase_t;
	typedef enum {SLOW_SINK, SLOW_SOURCE, FREE_FLOW} traffic_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [31:0]                  m_tdata;
	logic                         m_tlast;
	logic                         psel     = 1'b0;
	logic                         penable  = 1'b0;
	logic                         pwrite   = 1'b0;
	logic [dfbs_pkg::ADDR_W-1:0]  paddr    = '0;
	logic [31:0]                  pwdata   = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	// scanner state as the block should hold it
	logic [dfbs_pkg::MC_W-1:0]    cfg_modules = 7'd64;
	scan_phase_t                  scan_state  = PHASE_LOAD;
	int                           read_pos    = 0;
	bit                           primed      = 1'b0;
	logic                         hist_left  [HIST_DEPTH];
	logic                         hist_right [HIST_DEPTH];

	dfbs_pkg::res_t               tick_results_due [$];
	logic [7:0]                   bus_ticks [$];
	int                           items_queued = 0;
	int                           items_taken  = 0;
	int                           errors       = 0;
	int                           src_idle_pct = 0;
	int                           sink_idle_pct = 0;
	int                           holds_asked  = 0;
	int                           holds_served = 0;
	int                           hold_left    = 0;
	int                           quiet_cycles = 0;

	// sensor image used to build frames that change only here and there
	int                           gen_slot = 0;
	bit                           img_left  [HIST_DEPTH];
	bit                           img_right [HIST_DEPTH];

	dual_feedback_bus_scanner_top uut (.*);

	always #2 clk = ~clk;

	function automatic dfbs_pkg::res_t scan_tick(input logic bl, input logic br);
		dfbs_pkg::res_t r;
		int half;
		int pos;
		r = '0;
		half = int'(cfg_modules) / 2 * dfbs_pkg::MODULE_BITS;
		if (half == 0 || half > HIST_DEPTH)
			return r;
		if (scan_state == PHASE_LOAD) begin
			r.load_level = 1'b1;
			r.reset_level = 1'b1;
			r.clock_pulse = 1'b1;
			scan_state = PHASE_READ;
			read_pos = 0;
			return r;
		end
		pos = (read_pos >= half) ? half - 1 : read_pos;
		r.clock_pulse = 1'b1;
		if (!primed || hist_left[pos] != bl) begin
			r.left_report = 1'b1;
			r.left_sensor_id = dfbs_pkg::ID_W'(pos + 1);
			r.left_state = bl;
		end
		if (!primed || hist_right[pos] != br) begin
			r.right_report = 1'b1;
			r.right_sensor_id = dfbs_pkg::ID_W'(half + pos + 1);
			r.right_state = br;
		end
		hist_left[pos] = bl;
		hist_right[pos] = br;
		read_pos = pos + 1;
		if (read_pos >= half) begin
			r.frame_done = 1'b1;
			primed = 1'b1;
			scan_state = PHASE_LOAD;
			read_pos = 0;
		end
		return r;
	endfunction

	function automatic void apply_register(input int index, input logic [31:0] value);
		logic [dfbs_pkg::MC_W-1:0] v;
		v = value[dfbs_pkg::MC_W-1:0];
		if (index == int'(dfbs_pkg::REG_MODULE_COUNT) && !v[0] &&
				v <= dfbs_pkg::MAX_MODULES) begin
			cfg_modules = v;
			scan_state = PHASE_LOAD;
			read_pos = 0;
			primed = 1'b0;
			gen_slot = 0;
		end
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result(input logic [31:0] data, input logic last);
		dfbs_pkg::res_t got;
		dfbs_pkg::res_t want;
		got = dfbs_pkg::res_t'({last, data[26:0]});
		if (tick_results_due.size() == 0) begin
			$display("%0t: result with none expected, expected none, actual %h/%b",
				$time, data, last);
			errors++;
			return;
		end
		want = tick_results_due.pop_front();
		check_field("load_level", want.load_level, got.load_level);
		check_field("reset_level", want.reset_level, got.reset_level);
		check_field("clock_pulse", want.clock_pulse, got.clock_pulse);
		check_field("left_report", want.left_report, got.left_report);
		check_field("left_sensor_id", want.left_sensor_id, got.left_sensor_id);
		check_field("left_state", want.left_state, got.left_state);
		check_field("right_report", want.right_report, got.right_report);
		check_field("right_sensor_id", want.right_sensor_id, got.right_sensor_id);
		check_field("right_state", want.right_state, got.right_state);
		check_field("frame_done", want.frame_done, got.frame_done);
		check_field("tdata fill", 0, data[31:27]);
	endfunction

	// sender: one transaction per accepted tick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				tick_results_due.push_back(scan_tick(s_tdata[0], s_tdata[1]));
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (bus_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= bus_ticks.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver with random stalls and the occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata, m_tlast);
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[dual_feedback_bus_scanner_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_traffic(input traffic_t mode);
		case (mode)
			SLOW_SINK: begin
				src_idle_pct = 23;
				sink_idle_pct = 63;
			end
			SLOW_SOURCE: begin
				src_idle_pct = 63;
				sink_idle_pct = 23;
			end
			default: begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
		endcase
	endtask

	task automatic reg_write(input int index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dfbs_pkg::ADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(index, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_read(input int index, input logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= dfbs_pkg::ADDR_W'(4 * index);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d read mismatch, expected %0d, actual %0d",
				$time, index, want, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// pair is {right, left}
	task automatic push_tick(input logic [1:0] pair);
		bus_ticks.push_back({6'b0, pair});
		items_queued++;
	endtask

	task automatic feed_ticks(input int count, input int flip_pct);
		int half;
		int p;
		logic bl;
		logic br;
		for (int i = 0; i < count; i++) begin
			half = int'(cfg_modules) / 2 * dfbs_pkg::MODULE_BITS;
			bl = 1'($urandom);
			br = 1'($urandom);
			if (half != 0 && gen_slot != 0) begin
				p = gen_slot - 1;
				if ($urandom_range(99) >= 5) begin
					bl = ($urandom_range(99) < flip_pct) ? !img_left[p] : img_left[p];
					br = ($urandom_range(99) < flip_pct) ? !img_right[p] : img_right[p];
				end
				img_left[p] = bl;
				img_right[p] = br;
			end
			gen_slot = (half == 0) ? 0 : (gen_slot + 1) % (half + 1);
			push_tick({br, bl});
		end
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || tick_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		set_traffic(SLOW_SINK);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default setting, then a restart in the middle of its frame
		reg_read(dfbs_pkg::REG_MODULE_COUNT, 64);
		push_tick(2'b01); push_tick(2'b10); push_tick(2'b11);
		wait_drained();
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 2);
		// first frame reports all, second only the changed bits
		push_tick(2'b11); push_tick(2'b00); push_tick(2'b11); push_tick(2'b10);
		push_tick(2'b01); push_tick(2'b11); push_tick(2'b00); push_tick(2'b01);
		push_tick(2'b10);
		push_tick(2'b00); push_tick(2'b00); push_tick(2'b11); push_tick(2'b11);
		push_tick(2'b11); push_tick(2'b00); push_tick(2'b00); push_tick(2'b10);
		push_tick(2'b10);
		wait_drained();
		// same value written again still restarts the scan
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 2);
		push_tick(2'b11); push_tick(2'b00);
		wait_drained();
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 0);
		push_tick(2'b11); push_tick(2'b01);
		wait_drained();
		// odd, oversized and misaddressed writes leave the block idle
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 3);
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 66);
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 127);
		reg_write(REG_SPARE, 8);
		reg_read(dfbs_pkg::REG_MODULE_COUNT, 0);
		push_tick(2'b10);
		wait_drained();

		reg_write(dfbs_pkg::REG_MODULE_COUNT, 4);
		feed_ticks(130, 12);
		wait_drained();
		// only the low seven bits of the write count
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 32'hFFFF_FF82);
		reg_read(dfbs_pkg::REG_MODULE_COUNT, 2);
		feed_ticks(100, 20);
		wait_drained();
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 0);
		feed_ticks(30, 0);
		wait_drained();
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 6);
		feed_ticks(120, 8);
		wait_drained();

		set_traffic(SLOW_SOURCE);
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 16);
		feed_ticks(100, 6);
		wait_drained();
		feed_ticks(100, 6);
		wait_drained();
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 32);
		feed_ticks(80, 10);
		wait_drained();

		set_traffic(FREE_FLOW);
		reg_write(dfbs_pkg::REG_MODULE_COUNT, 64);
		reg_read(dfbs_pkg::REG_MODULE_COUNT, 64);
		holds_asked++;
		feed_ticks(520, 3);
		wait_drained();
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("[dual_feedback_bus_scanner_top] OK");
		else
			$display("[dual_feedback_bus_scanner_top] ERROR");
		$finish;
	end

endmodule

FILE: dual_feedback_bus_scanner_top.f
+incdir+sv
sv/dfbs_pkg.sv
sv/dfbs_cell.sv
sv/dfbs_seq.sv
sv/dual_feedback_bus_scanner_top.sv
tb/sv/dual_feedback_bus_scanner_top_tb.sv
